### rtl/ftbe_pkg.sv
// Shared types and constants for the frame timestamp base extender.
// No dependencies; used by every module of the block.
package ftbe_pkg;

	// input op codes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// arithmetic constants
	localparam int unsigned MsPerSec   = 1000;
	localparam int unsigned UsecPerSec = 1000000;
	localparam logic [41:0] REFRESH_FLOOR_MS = 42'd50;
	localparam logic [31:0] FREQ_RESET = 32'd1000000;
	localparam logic [63:0] SIGN_BIAS  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] WRAP_32    = 64'h0000_0001_0000_0000;

	// divider geometry: 84-bit dividend covers a 64-bit value times 1e6
	localparam int unsigned DIV_W   = 84;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned SHORT_W = 42;
	localparam int unsigned MUL_KW  = 20;
	localparam int unsigned PROD_W  = 52;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_DIV_D,
		ST_MUL_P,
		ST_DIV_P,
		ST_DECIDE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_T,
		ST_FINISH
	} state_t;

	// multiplier operand select
	typedef enum logic [1:0] {
		MS_DIFF,
		MS_PREV,
		MS_LO,
		MS_HI
	} mul_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     clear;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     take_tick;
		logic     take_prev;
		logic     decide;
		logic     save_lo;
		logic     load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

### rtl/ftbe_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ftbe_pkg for widths.
module ftbe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ftbe_pkg::DIV_W-1:0]    dividend,
	input  logic [ftbe_pkg::CNT_W-1:0]    steps,
	input  logic [31:0]                   divisor,
	output logic                          busy,
	output logic                          done,
	output logic [ftbe_pkg::DIV_W-1:0]    quotient
);

	logic                       busy_q;
	logic                       done_q;
	logic [ftbe_pkg::CNT_W-1:0] cnt_q;
	logic [31:0]                rem_q;
	logic [31:0]                dvs_q;
	logic [ftbe_pkg::DIV_W-1:0] dq_q;
	logic [32:0]                shifted;
	logic [32:0]                diff;
	logic                       ge;

	// trial subtract
	always_comb begin
		shifted = {rem_q, dq_q[ftbe_pkg::DIV_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - ftbe_pkg::CNT_W'(1);
				if (cnt_q == ftbe_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			dq_q  <= {dq_q[ftbe_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

### rtl/ftbe_dp.sv
// Datapath: state registers, shared multiplier, divider and output register.
// Depends on ftbe_pkg and ftbe_div.
module ftbe_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ftbe_pkg::cmd_t       cmd,
	output ftbe_pkg::sts_t       sts,
	input  logic                 cfg_valid,
	input  logic [31:0]          cfg_data,
	input  logic [31:0]          source_ticks,
	input  logic [63:0]          host_time_ms,
	input  logic [63:0]          device_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          timestamp_usec,
	output logic                 base_refreshed
);

	logic [31:0] freq_q;
	logic [31:0] freq_eff;
	logic [31:0] src_q;
	logic [63:0] host_q;
	logic [63:0] dev_q;
	logic [31:0] prev_ticks_q;
	logic [63:0] prev_host_q;
	logic [63:0] base_q;
	logic [ftbe_pkg::SHORT_W-1:0] tick_mag_q;
	logic [ftbe_pkg::SHORT_W-1:0] prev_ms_q;
	logic [ftbe_pkg::PROD_W-1:0]  plo_q;
	logic        refresh_q;
	logic        out_valid_q;
	logic [63:0] ts_q;
	logic        refreshed_q;

	logic        decrease;
	logic [31:0] mag32;
	logic [31:0] mul_a;
	logic [ftbe_pkg::MUL_KW-1:0] mul_k;
	logic [ftbe_pkg::PROD_W-1:0] prod;
	logic [ftbe_pkg::DIV_W-1:0]  div_in;
	logic [ftbe_pkg::CNT_W-1:0]  div_steps;
	logic [ftbe_pkg::DIV_W-1:0]  quot;
	logic        div_busy;
	logic        div_done;
	logic [63:0] tick_ms_u;
	logic [63:0] host_ms_u;
	logic [63:0] rhs_u;
	logic        abnormal;
	logic        refresh;
	logic [63:0] new_base;
	logic        out_free;

	// frequency register, zero treated as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= ftbe_pkg::FREQ_RESET;
		end else if (cfg_valid) begin
			freq_q <= cfg_data;
		end
	end
	assign freq_eff = (freq_q == 32'd0) ? 32'd1 : freq_q;

	// tick difference magnitude
	always_comb begin
		decrease = src_q < prev_ticks_q;
		mag32    = decrease ? (prev_ticks_q - src_q) : (src_q - prev_ticks_q);
	end

	// shared constant multiplier and divider operand
	always_comb begin
		case (cmd.mul_sel)
			ftbe_pkg::MS_DIFF: begin
				mul_a = mag32;
				mul_k = ftbe_pkg::MUL_KW'(ftbe_pkg::MsPerSec);
			end
			ftbe_pkg::MS_PREV: begin
				mul_a = prev_ticks_q;
				mul_k = ftbe_pkg::MUL_KW'(ftbe_pkg::MsPerSec);
			end
			ftbe_pkg::MS_LO: begin
				mul_a = src_q;
				mul_k = ftbe_pkg::MUL_KW'(ftbe_pkg::UsecPerSec);
			end
			default: begin
				mul_a = base_q[63:32];
				mul_k = ftbe_pkg::MUL_KW'(ftbe_pkg::UsecPerSec);
			end
		endcase
		prod = ftbe_pkg::PROD_W'(mul_a) * ftbe_pkg::PROD_W'(mul_k);
		if (cmd.mul_sel == ftbe_pkg::MS_HI) begin
			div_in    = {prod, 32'd0} + ftbe_pkg::DIV_W'(plo_q);
			div_steps = ftbe_pkg::CNT_W'(ftbe_pkg::DIV_W);
		end else begin
			div_in    = {prod[ftbe_pkg::SHORT_W-1:0], {(ftbe_pkg::DIV_W - ftbe_pkg::SHORT_W){1'b0}}};
			div_steps = ftbe_pkg::CNT_W'(ftbe_pkg::SHORT_W);
		end
	end

	ftbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_in),
		.steps    (div_steps),
		.divisor  (freq_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	// refresh decision and new base
	always_comb begin
		tick_ms_u = decrease ? (64'd0 - 64'(tick_mag_q)) : 64'(tick_mag_q);
		host_ms_u = host_q - prev_host_q;
		rhs_u     = tick_ms_u + 64'(prev_ms_q >> 1);
		abnormal  = (host_ms_u ^ ftbe_pkg::SIGN_BIAS) >= (rhs_u ^ ftbe_pkg::SIGN_BIAS);
		refresh   = (base_q == 64'd0)
			|| ((decrease || abnormal) && (src_q != 32'd0 || prev_ticks_q != 32'd0))
			|| (prev_ms_q <= ftbe_pkg::REFRESH_FLOOR_MS);
		new_base  = dev_q;
		if (dev_q[31:0] <= src_q && dev_q > ftbe_pkg::WRAP_32) begin
			new_base = dev_q - ftbe_pkg::WRAP_32;
		end
	end

	// request capture and intermediate results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q  <= source_ticks;
			host_q <= host_time_ms;
			dev_q  <= device_time;
		end
		if (cmd.take_tick) begin
			tick_mag_q <= quot[ftbe_pkg::SHORT_W-1:0];
		end
		if (cmd.take_prev) begin
			prev_ms_q <= quot[ftbe_pkg::SHORT_W-1:0];
		end
		if (cmd.decide) begin
			refresh_q <= refresh;
		end
		if (cmd.save_lo) begin
			plo_q <= prod;
		end
	end

	// extender state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ticks_q <= '0;
			prev_host_q  <= '0;
			base_q       <= '0;
		end else if (cmd.clear) begin
			prev_ticks_q <= '0;
			prev_host_q  <= '0;
			base_q       <= '0;
		end else if (cmd.decide) begin
			prev_ticks_q <= src_q;
			prev_host_q  <= host_q;
			if (refresh) begin
				base_q <= new_base;
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ts_q        <= (|quot[ftbe_pkg::DIV_W-1:64]) ? '1 : quot[63:0];
			refreshed_q <= refresh_q;
		end
	end

	assign sts.div_busy   = div_busy;
	assign sts.div_done   = div_done;
	assign sts.out_free   = out_free;
	assign out_valid      = out_valid_q;
	assign timestamp_usec = ts_q;
	assign base_refreshed = refreshed_q;

endmodule

### rtl/ftbe_ctrl.sv
// Controller: sequences multiply and divide passes for each frame request.
// Depends on ftbe_pkg.
module ftbe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 op,
	output logic                 in_stall,
	input  ftbe_pkg::sts_t       sts,
	output ftbe_pkg::cmd_t       cmd
);

	ftbe_pkg::state_t state_q;
	ftbe_pkg::state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ftbe_pkg::ST_IDLE: begin
				if (in_valid && op == ftbe_pkg::OP_FRAME) state_n = ftbe_pkg::ST_MUL_D;
			end
			ftbe_pkg::ST_MUL_D:  state_n = ftbe_pkg::ST_DIV_D;
			ftbe_pkg::ST_DIV_D: begin
				if (sts.div_done) state_n = ftbe_pkg::ST_MUL_P;
			end
			ftbe_pkg::ST_MUL_P:  state_n = ftbe_pkg::ST_DIV_P;
			ftbe_pkg::ST_DIV_P: begin
				if (sts.div_done) state_n = ftbe_pkg::ST_DECIDE;
			end
			ftbe_pkg::ST_DECIDE: state_n = ftbe_pkg::ST_MUL_LO;
			ftbe_pkg::ST_MUL_LO: state_n = ftbe_pkg::ST_MUL_HI;
			ftbe_pkg::ST_MUL_HI: state_n = ftbe_pkg::ST_DIV_T;
			ftbe_pkg::ST_DIV_T: begin
				if (sts.div_done) state_n = ftbe_pkg::ST_FINISH;
			end
			ftbe_pkg::ST_FINISH: begin
				if (sts.out_free) state_n = ftbe_pkg::ST_IDLE;
			end
			default: state_n = ftbe_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = ftbe_pkg::MS_DIFF;
		in_stall    = 1'b1;
		unique case (state_q)
			ftbe_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid && op == ftbe_pkg::OP_FRAME;
				cmd.clear   = in_valid && op == ftbe_pkg::OP_CLEAR;
			end
			ftbe_pkg::ST_MUL_D: begin
				cmd.mul_sel   = ftbe_pkg::MS_DIFF;
				cmd.div_start = 1'b1;
			end
			ftbe_pkg::ST_DIV_D:  cmd.take_tick = sts.div_done;
			ftbe_pkg::ST_MUL_P: begin
				cmd.mul_sel   = ftbe_pkg::MS_PREV;
				cmd.div_start = 1'b1;
			end
			ftbe_pkg::ST_DIV_P:  cmd.take_prev = sts.div_done;
			ftbe_pkg::ST_DECIDE: cmd.decide = 1'b1;
			ftbe_pkg::ST_MUL_LO: begin
				cmd.mul_sel = ftbe_pkg::MS_LO;
				cmd.save_lo = 1'b1;
			end
			ftbe_pkg::ST_MUL_HI: begin
				cmd.mul_sel   = ftbe_pkg::MS_HI;
				cmd.div_start = 1'b1;
			end
			ftbe_pkg::ST_DIV_T:  cmd.mul_sel = ftbe_pkg::MS_HI;
			ftbe_pkg::ST_FINISH: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/frame_timestamp_base_extender_core.sv
// Top level of the frame timestamp base extender.
// Depends on ftbe_pkg, ftbe_ctrl, ftbe_dp (which holds ftbe_div).
//
// Usage:
//   Input channel (in_valid / in_stall): one request carries op, source_ticks,
//   host_time_ms and device_time. op frame converts a 32-bit tick stamp into
//   a 64-bit microsecond timestamp; op clear zeroes the stored state in the
//   accept cycle and gives no result.
//   Output channel (out_valid / out_stall): one result per frame request,
//   timestamp_usec and base_refreshed, held in an output register.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes clock_freq_hz;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A frame request runs from accept to result through two short divider
//   passes (start, 42 steps, done), the decision step, two multiply steps,
//   a long pass (84 steps, done) and the output load. A new frame is
//   accepted only once the last result is loaded; clear requests keep the
//   block idle and may follow back to back.
//   in_stall is high from a frame accept until its result enters the
//   output register.
// Reset: asynchronous, clears state to zero and clock_freq_hz to 1000000.
// A stalled receiver holds the result; the block then waits before loading
// the next result, while the next request may already be in work.
module frame_timestamp_base_extender_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] source_ticks,
	input  logic [63:0] host_time_ms,
	input  logic [63:0] device_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] timestamp_usec,
	output logic        base_refreshed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	ftbe_pkg::cmd_t cmd;
	ftbe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ftbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftbe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.source_ticks   (source_ticks),
		.host_time_ms   (host_time_ms),
		.device_time    (device_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.timestamp_usec (timestamp_usec),
		.base_refreshed (base_refreshed)
	);

	// divider is never restarted while iterating
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

	// a frame request makes the block busy in the next cycle
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == ftbe_pkg::OP_FRAME) |=> in_stall)
		else $error("frame accepted but block not busy");

	// at most one datapath update step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_tick, cmd.take_prev, cmd.decide, cmd.save_lo, cmd.load_out}))
		else $error("overlapping datapath updates");

endmodule
